>>> src/mhpq_pkg.sv
package mhpq_pkg;

    localparam int CAPACITY = 16;
    localparam int ADDR_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int NODE_W = ADDR_W + 2;

    localparam logic FUNC_INSERT = 1'b0;
    localparam logic FUNC_REMOVE = 1'b1;

    localparam logic [1:0] STATUS_DONE  = 2'd0;
    localparam logic [1:0] STATUS_FULL  = 2'd1;
    localparam logic [1:0] STATUS_EMPTY = 2'd2;

    typedef struct packed {
        logic               func;
        logic signed [31:0] value;
    } mhpq_in_t;

    typedef struct packed {
        logic signed [31:0] min_value;
        logic [4:0]         entry_total;
        logic [1:0]         status;
    } mhpq_out_t;

    typedef struct packed {
        logic               we;
        logic [ADDR_W-1:0]  waddr;
        logic signed [31:0] wdata;
        logic [ADDR_W-1:0]  ra;
        logic [ADDR_W-1:0]  rb;
    } mhpq_mem_req_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_UP_RD,
        ST_UP_CMP,
        ST_LAST,
        ST_DN_RD,
        ST_DN_CMP
    } mhpq_state_t;

endpackage

>>> src/min_heap_priority_queue_unit.sv
// Bounded min-heap priority queue of signed 32-bit values.
// A command word is taken on item at a rising edge where start is high and
// busy is low. Its func field selects an insert of value or a removal of the
// smallest value. Each command produces exactly one result word on result,
// marked by done for a single cycle; the receiver cannot stall it.
// The result carries the smallest value held after the command (zero when
// empty), the number of values held and a status: done, insert refused
// because full, or removal refused because empty.
// Refused commands, inserts into an empty heap and removals that empty the
// heap answer in the cycle after acceptance. An insert sifts up level by
// level, a parent read then a compare, and takes a final write step when the
// value reaches the root; a removal reads the last entry and sifts down level
// by level, both children read together on the two read ports of the heap
// memory. Each level waits on the registered read of the heap memory. Busy
// falls as the result is issued, so the next command can be accepted at the
// edge that ends the result cycle.
// Reset empties the heap at once; the memory itself is not cleared.
module min_heap_priority_queue_unit
    import mhpq_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    output logic      busy,
    input  mhpq_in_t  item,
    output logic      done,
    output mhpq_out_t result
);

    mhpq_state_t        state_reg, state_next;
    logic [ADDR_W-1:0]  pos_reg, pos_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic signed [31:0] key_reg, key_next;
    logic signed [31:0] root_reg, root_next;
    logic               done_reg, done_next;
    mhpq_out_t          result_reg, result_next;

    mhpq_mem_req_t      req;
    logic signed [31:0] rdata_a;
    logic signed [31:0] rdata_b;

    logic [ADDR_W-1:0]  pos_dec;
    logic [ADDR_W-1:0]  parent;
    logic [NODE_W-1:0]  left_node;
    logic [NODE_W-1:0]  right_node;
    logic [CNT_W-1:0]   count_dec;
    logic               fin;
    logic [1:0]         fin_status;
    logic               take;
    logic [ADDR_W-1:0]  cand;
    logic signed [31:0] cand_val;

    mhpq_store u_store
    (
        .clk     (clk),
        .req     (req),
        .rdata_a (rdata_a),
        .rdata_b (rdata_b)
    );

    assign pos_dec    = pos_reg - 1'b1;
    assign parent     = {1'b0, pos_dec[ADDR_W-1:1]};
    assign left_node  = {1'b0, pos_reg, 1'b1};
    assign right_node = left_node + 1'b1;
    assign count_dec  = count_reg - 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg    <= pos_next;
        key_reg    <= key_next;
        root_reg   <= root_next;
        result_reg <= result_next;
    end

    always_comb
    begin
        state_next  = state_reg;
        pos_next    = pos_reg;
        count_next  = count_reg;
        key_next    = key_reg;
        fin         = 1'b0;
        fin_status  = STATUS_DONE;
        take        = 1'b0;
        cand        = pos_reg;
        cand_val    = key_reg;
        req.we      = 1'b0;
        req.waddr   = pos_reg;
        req.wdata   = key_reg;
        req.ra      = parent;
        req.rb      = right_node[ADDR_W-1:0];

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    if (item.func == FUNC_INSERT)
                    begin
                        if (count_reg == CNT_W'(CAPACITY))
                        begin
                            fin        = 1'b1;
                            fin_status = STATUS_FULL;
                        end
                        else
                        begin
                            count_next = count_reg + 1'b1;
                            key_next   = item.value;
                            pos_next   = count_reg[ADDR_W-1:0];
                            if (count_reg == '0)
                            begin
                                req.we    = 1'b1;
                                req.waddr = '0;
                                req.wdata = item.value;
                                fin       = 1'b1;
                            end
                            else
                            begin
                                state_next = ST_UP_RD;
                            end
                        end
                    end
                    else
                    begin
                        if (count_reg == '0)
                        begin
                            fin        = 1'b1;
                            fin_status = STATUS_EMPTY;
                        end
                        else
                        begin
                            count_next = count_dec;
                            if (count_reg == CNT_W'(1))
                            begin
                                fin = 1'b1;
                            end
                            else
                            begin
                                req.ra     = count_dec[ADDR_W-1:0];
                                state_next = ST_LAST;
                            end
                        end
                    end
                end
            end

            ST_UP_RD:
            begin
                req.ra     = parent;
                state_next = ST_UP_CMP;
            end

            ST_UP_CMP:
            begin
                req.we = 1'b1;
                if (key_reg < rdata_a)
                begin
                    req.wdata = rdata_a;
                    pos_next  = parent;
                    if (parent == '0)
                    begin
                        // The new value ends at the root; write it there next.
                        // Both ports read the old root, so no child is taken.
                        req.rb     = parent;
                        state_next = ST_DN_CMP;
                    end
                    else
                    begin
                        state_next = ST_UP_RD;
                    end
                end
                else
                begin
                    fin        = 1'b1;
                    state_next = ST_IDLE;
                end
            end

            ST_LAST:
            begin
                key_next   = rdata_a;
                pos_next   = '0;
                state_next = ST_DN_RD;
            end

            ST_DN_RD:
            begin
                req.ra     = left_node[ADDR_W-1:0];
                req.rb     = right_node[ADDR_W-1:0];
                state_next = ST_DN_CMP;
            end

            ST_DN_CMP:
            begin
                if (left_node < NODE_W'(count_reg) && rdata_a < key_reg)
                begin
                    take     = 1'b1;
                    cand     = left_node[ADDR_W-1:0];
                    cand_val = rdata_a;
                end
                if (right_node < NODE_W'(count_reg) && rdata_b < cand_val)
                begin
                    take     = 1'b1;
                    cand     = right_node[ADDR_W-1:0];
                    cand_val = rdata_b;
                end
                req.we = 1'b1;
                if (take)
                begin
                    req.wdata  = cand_val;
                    pos_next   = cand;
                    state_next = ST_DN_RD;
                end
                else
                begin
                    fin        = 1'b1;
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (req.we && req.waddr == '0)
        begin
            root_next = req.wdata;
        end
        else
        begin
            root_next = root_reg;
        end

        done_next               = fin;
        result_next.min_value   = (count_next != '0) ? root_next : 32'sd0;
        result_next.entry_total = 5'(count_next);
        result_next.status      = fin_status;
    end

    assign busy   = (state_reg != ST_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("entry count exceeds capacity");

    a_full_total: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg && result_reg.status == STATUS_FULL
        |-> result_reg.entry_total == 5'(CAPACITY))
        else $error("full refusal with heap not full");

    a_empty_total: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg && (result_reg.status == STATUS_EMPTY || result_reg.entry_total == 5'd0)
        |-> result_reg.min_value == 32'sd0)
        else $error("empty heap reports a nonzero minimum");

    a_up_not_root: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_UP_RD || state_reg == ST_UP_CMP |-> pos_reg != '0)
        else $error("sift up running at the root");

    a_done_ends_work: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !$past(state_reg == ST_UP_RD || state_reg == ST_DN_RD
                            || state_reg == ST_LAST))
        else $error("result issued from a read cycle");

endmodule

>>> src/mhpq_store.sv
module mhpq_store
    import mhpq_pkg::*;
(
    input  logic               clk,
    input  mhpq_mem_req_t      req,
    output logic signed [31:0] rdata_a,
    output logic signed [31:0] rdata_b
);

    logic signed [31:0] mem [CAPACITY];
    logic signed [31:0] rdata_a_reg;
    logic signed [31:0] rdata_b_reg;

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
        rdata_a_reg <= mem[req.ra];
        rdata_b_reg <= mem[req.rb];
    end

    assign rdata_a = rdata_a_reg;
    assign rdata_b = rdata_b_reg;

endmodule
